/* hdl/btsu_pkg.sv */
// Package for the bit test and scan unit: operation codes, size codes,
// widths and the structs passed between pipeline stages.
// Depends on nothing; every other file imports it.
package btsu_pkg;

    localparam int DATA_W   = 64;
    localparam int IDX_W    = 6;
    localparam int GROUP_W  = 16;
    localparam int N_GROUPS = DATA_W / GROUP_W;
    localparam int GIDX_W   = 4;
    localparam int GSEL_W   = 2;

    typedef enum logic [2:0] {
        OP_BT  = 3'd0,
        OP_BTS = 3'd1,
        OP_BTR = 3'd2,
        OP_BTC = 3'd3,
        OP_BSF = 3'd4,
        OP_BSR = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        SIZE_16 = 2'd0,
        SIZE_32 = 2'd1,
        SIZE_64 = 2'd2
    } t_size;

    typedef struct packed {
        logic              valid;
        logic [2:0]        op;
        logic              is_scan;
        logic              is_rev;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] bit_mask;
    } t_s1;

    typedef struct packed {
        logic                           valid;
        logic                           is_scan;
        logic                           is_rev;
        logic [DATA_W-1:0]              bt_value;
        logic                           bt_write;
        logic                           bt_flag;
        logic [N_GROUPS-1:0]            grp_nz;
        logic [N_GROUPS-1:0][GIDX_W-1:0] grp_idx;
    } t_s2;

endpackage

/* hdl/btsu_prep.sv */
// First stage: masks the operand to its size, decodes the bit index into a
// one-hot mask and bit-reverses the source for a reverse scan.
// Depends on btsu_pkg.
module btsu_prep
    import btsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_operation,
    input  logic [1:0]        i_size_code,
    input  logic [DATA_W-1:0] i_operand_value,
    input  logic [DATA_W-1:0] i_bit_select,
    output t_s1               o_s1
);

    t_s1               r_s1;
    t_s1               n_s1;
    logic [DATA_W-1:0] size_mask;
    logic [DATA_W-1:0] masked;
    logic [IDX_W-1:0]  idx;

    always_comb begin
        case (i_size_code)
            SIZE_16: begin
                size_mask = {{(DATA_W-16){1'b0}}, {16{1'b1}}};
                idx       = {2'b00, i_bit_select[3:0]};
            end
            SIZE_32: begin
                size_mask = {{(DATA_W-32){1'b0}}, {32{1'b1}}};
                idx       = {1'b0, i_bit_select[4:0]};
            end
            default: begin
                size_mask = {DATA_W{1'b1}};
                idx       = i_bit_select[IDX_W-1:0];
            end
        endcase
        masked = i_operand_value & size_mask;

        n_s1.valid    = i_valid;
        n_s1.op       = i_operation;
        n_s1.is_scan  = (i_operation == OP_BSF) || (i_operation == OP_BSR);
        n_s1.is_rev   = (i_operation == OP_BSR);
        n_s1.bit_mask = {{(DATA_W-1){1'b0}}, 1'b1} << idx;
        for (int i = 0; i < DATA_W; i++) begin
            n_s1.val[i] = n_s1.is_rev ? masked[DATA_W-1-i] : masked[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

/* hdl/btsu_exec.sv */
// Second stage: performs the bit test and modify, and finds the lowest set
// bit inside each 16-bit group of the scan source.
// Depends on btsu_pkg.
module btsu_exec
    import btsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    t_s2 r_s2;
    t_s2 n_s2;

    function automatic logic [GIDX_W-1:0] lowest16(input logic [GROUP_W-1:0] v);
        logic [GIDX_W-1:0] pos;
        pos = '0;
        for (int i = GROUP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = GIDX_W'(i);
            end
        end
        return pos;
    endfunction

    always_comb begin
        n_s2.valid   = i_s1.valid;
        n_s2.is_scan = i_s1.is_scan;
        n_s2.is_rev  = i_s1.is_rev;
        n_s2.bt_flag = |(i_s1.val & i_s1.bit_mask);
        case (i_s1.op)
            OP_BTS: begin
                n_s2.bt_value = i_s1.val | i_s1.bit_mask;
                n_s2.bt_write = 1'b1;
            end
            OP_BTR: begin
                n_s2.bt_value = i_s1.val & ~i_s1.bit_mask;
                n_s2.bt_write = 1'b1;
            end
            OP_BTC: begin
                n_s2.bt_value = i_s1.val ^ i_s1.bit_mask;
                n_s2.bt_write = 1'b1;
            end
            default: begin
                n_s2.bt_value = i_s1.val;
                n_s2.bt_write = 1'b0;
            end
        endcase
        for (int g = 0; g < N_GROUPS; g++) begin
            n_s2.grp_nz[g]  = |i_s1.val[g*GROUP_W +: GROUP_W];
            n_s2.grp_idx[g] = lowest16(i_s1.val[g*GROUP_W +: GROUP_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

/* hdl/btsu_final.sv */
// Third stage: picks the first nonzero group for a scan, forms the bit
// index and registers the result word with its strobe.
// Depends on btsu_pkg.
module btsu_final
    import btsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_s2               i_s2,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_result_value,
    output logic              o_result_write,
    output logic              o_flag_kind,
    output logic              o_flag_value
);

    logic              r_valid;
    logic [DATA_W-1:0] r_value;
    logic              r_write;
    logic              r_kind;
    logic              r_flag;
    logic [DATA_W-1:0] n_value;
    logic              n_write;
    logic              n_flag;
    logic [GSEL_W-1:0] gsel;
    logic [IDX_W-1:0]  pos;

    always_comb begin
        gsel = '0;
        for (int g = N_GROUPS - 1; g >= 0; g--) begin
            if (i_s2.grp_nz[g]) begin
                gsel = GSEL_W'(g);
            end
        end
        pos = {gsel, i_s2.grp_idx[gsel]};
        if (i_s2.is_rev) begin
            pos = IDX_W'(DATA_W - 1) - pos;
        end

        if (i_s2.is_scan) begin
            if (|i_s2.grp_nz) begin
                n_value = {{(DATA_W-IDX_W){1'b0}}, pos};
                n_write = 1'b1;
                n_flag  = 1'b0;
            end else begin
                n_value = '0;
                n_write = 1'b0;
                n_flag  = 1'b1;
            end
        end else begin
            n_value = i_s2.bt_value;
            n_write = i_s2.bt_write;
            n_flag  = i_s2.bt_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
            r_value <= n_value;
            r_write <= n_write;
            r_kind  <= i_s2.is_scan;
            r_flag  <= n_flag;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_result_write = r_write;
    assign o_flag_kind    = r_kind;
    assign o_flag_value   = r_flag;

endmodule

/* hdl/bit_test_and_scan_unit.sv */
// Top level of the bit test and scan unit: three pipeline stages.
// Depends on btsu_pkg, btsu_prep, btsu_exec and btsu_final.
//
//   Channel  | Handshake           | Words
//   ---------+---------------------+-----------------------------------------------
//   command  | start in, busy out  | i_operation, i_size_code, i_operand_value,
//            |                     | i_bit_select
//   result   | o_valid strobe out  | o_result_value, o_result_write, o_flag_kind,
//            |                     | o_flag_value
//
// A word is taken every cycle; its result strobes once it has passed the three
// registered stages in order: decode, test or group scan, and group select.
// Busy is always low, since nothing downstream can stall and no stage ever
// holds. Reset is synchronous and clears only the valid bits.
module bit_test_and_scan_unit
    import btsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_operation,
    input  logic [1:0]        i_size_code,
    input  logic [DATA_W-1:0] i_operand_value,
    input  logic [DATA_W-1:0] i_bit_select,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_result_value,
    output logic              o_result_write,
    output logic              o_flag_kind,
    output logic              o_flag_value
);

    t_s1 s1;
    t_s2 s2;

    assign busy = 1'b0;

    btsu_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_operation     (i_operation),
        .i_size_code     (i_size_code),
        .i_operand_value (i_operand_value),
        .i_bit_select    (i_bit_select),
        .o_s1            (s1)
    );

    btsu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    btsu_final u_final (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s2           (s2),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_result_write (o_result_write),
        .o_flag_kind    (o_flag_kind),
        .o_flag_value   (o_flag_value)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("Accepted word did not produce a result after three cycles.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("Result strobe without a matching accepted word.");

    a_scan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flag_kind && o_flag_value) |-> (!o_result_write && o_result_value == '0))
        else $error("Scan of a zero source wrote back or returned a nonzero value.");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flag_kind && !o_flag_value)
            |-> (o_result_write && o_result_value[DATA_W-1:IDX_W] == '0))
        else $error("Scan of a nonzero source returned an index out of range.");

endmodule
